// File: rtl/core/amhpq_pkg.sv
// ----------------------------------------------------------------------------
// amhpq_pkg
// shared types, sizes and compare helpers for the magnitude-ordered heap queue
// ----------------------------------------------------------------------------
package amhpq_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int LEVELS     = $clog2(HEAP_DEPTH + 1);
  localparam int SLOT_W     = LEVELS - 1;
  localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] value;
  } amhpq_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     heap_was_empty;
  } amhpq_res_t;

  // walker handed from one level cell to the next
  typedef struct packed {
    logic              valid;
    logic              is_pop;
    logic [DATA_W-1:0] carry;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  gidx;
    logic [CNT_W-1:0]  path;
    logic [LVL_W-1:0]  rem;
  } amhpq_tok_t;

  typedef struct packed {
    logic [SLOT_W-1:0] addr_a;
    logic [SLOT_W-1:0] addr_b;
  } amhpq_rd_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } amhpq_wr_t;

  typedef struct packed {
    logic              en;
    logic [LVL_W-1:0]  lvl;
    logic [SLOT_W-1:0] slot;
  } amhpq_fetch_t;

  // true when a must sit above b: smaller magnitude, then smaller signed value
  function automatic logic goes_before(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    ma = a[DATA_W-1] ? (~a + 1'b1) : a;
    mb = b[DATA_W-1] ? (~b + 1'b1) : b;
    if (ma != mb) begin
      return ma < mb;
    end
    return {~a[DATA_W-1], a[DATA_W-2:0]} < {~b[DATA_W-1], b[DATA_W-2:0]};
  endfunction

  // index of the highest set bit
  function automatic logic [LVL_W-1:0] msb_index(input logic [CNT_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (x[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/amhpq_ram.sv
// ----------------------------------------------------------------------------
// amhpq_ram
// one write port, two registered read ports
// ----------------------------------------------------------------------------
module amhpq_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  output logic [W-1:0]  rdata_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_b
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/amhpq_cell.sv
// ----------------------------------------------------------------------------
// amhpq_cell
// one heap level: reads its level memory, compares, writes, hands on the walker
// ----------------------------------------------------------------------------
module amhpq_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  amhpq_pkg::amhpq_tok_t         tok_in,
  input  logic [amhpq_pkg::CNT_W-1:0]   count,
  input  logic [amhpq_pkg::DATA_W-1:0]  rdata_a,
  input  logic [amhpq_pkg::DATA_W-1:0]  rdata_b,
  output amhpq_pkg::amhpq_rd_t          rd,
  output amhpq_pkg::amhpq_wr_t          wr_own,
  output amhpq_pkg::amhpq_wr_t          wr_up,
  output amhpq_pkg::amhpq_tok_t         tok_out,
  output logic                          done
);
  import amhpq_pkg::*;

  amhpq_tok_t        tok_r1;
  amhpq_tok_t        tok_r2;

  logic [SLOT_W:0]   rd_dbl;
  logic [SLOT_W-1:0] rd_kid_l;

  logic [SLOT_W:0]   dbl;
  logic [SLOT_W-1:0] kid_l;
  logic [SLOT_W-1:0] kid_r;
  logic [CNT_W:0]    g_l;
  logic [CNT_W:0]    g_r;
  logic              l_ok;
  logic              r_ok;
  logic              lt_lv;
  logic              lt_rv;
  logic              lt_rl;
  logic              pick_l;
  logic              pick_r;
  logic [DATA_W-1:0] c_val;
  logic [SLOT_W-1:0] c_slot;
  logic [CNT_W:0]    c_g;
  logic [CNT_W+1:0]  c_gk;
  logic              c_leaf;
  logic [LVL_W-1:0]  rem_m1;
  logic              dir;
  logic              swap;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_r1 <= '0;
      tok_r2 <= '0;
    end else begin
      tok_r1 <= tok_in;
      tok_r2 <= tok_r1;
    end
  end

  // read: own node on insert, both children on pop
  assign rd_dbl    = {tok_r1.slot, 1'b0};
  assign rd_kid_l  = rd_dbl[SLOT_W-1:0];
  assign rd.addr_a = tok_r1.is_pop ? rd_kid_l : tok_r1.slot;
  assign rd.addr_b = rd_kid_l | SLOT_W'(1);

  // children of the hole one level up
  assign dbl   = {tok_r2.slot, 1'b0};
  assign kid_l = dbl[SLOT_W-1:0];
  assign kid_r = kid_l | SLOT_W'(1);
  assign g_l   = {tok_r2.gidx, 1'b0} + (CNT_W+1)'(1);
  assign g_r   = g_l + (CNT_W+1)'(1);
  assign l_ok  = g_l < {1'b0, count};
  assign r_ok  = g_r < {1'b0, count};

  assign lt_lv = goes_before(rdata_a, tok_r2.carry);
  assign lt_rv = goes_before(rdata_b, tok_r2.carry);
  assign lt_rl = goes_before(rdata_b, rdata_a);

  always_comb begin
    if (l_ok && lt_lv) begin
      pick_r = r_ok && lt_rl;
      pick_l = !pick_r;
    end else begin
      pick_l = 1'b0;
      pick_r = r_ok && lt_rv;
    end
  end

  assign c_val  = pick_r ? rdata_b : rdata_a;
  assign c_slot = pick_r ? kid_r : kid_l;
  assign c_g    = pick_r ? g_r : g_l;
  assign c_gk   = {c_g, 1'b0} + (CNT_W+2)'(1);
  assign c_leaf = c_gk >= {2'b00, count};

  assign rem_m1 = tok_r2.rem - LVL_W'(1);
  assign dir    = tok_r2.path[rem_m1];
  assign swap   = goes_before(tok_r2.carry, rdata_a);

  always_comb begin
    wr_own  = '0;
    wr_up   = '0;
    tok_out = '0;
    done    = 1'b0;
    if (tok_r2.valid) begin
      if (!tok_r2.is_pop) begin
        wr_own.addr = tok_r2.slot;
        wr_own.data = tok_r2.carry;
        if (tok_r2.rem == '0) begin
          // target slot of the new entry
          wr_own.en = 1'b1;
          done      = 1'b1;
        end else begin
          wr_own.en     = swap;
          tok_out       = tok_r2;
          tok_out.carry = swap ? rdata_a : tok_r2.carry;
          tok_out.slot  = kid_l | SLOT_W'(dir);
          tok_out.rem   = rem_m1;
        end
      end else begin
        wr_up.en   = 1'b1;
        wr_up.addr = tok_r2.slot;
        if (!pick_l && !pick_r) begin
          // moved entry settles in the hole
          wr_up.data = tok_r2.carry;
          done       = 1'b1;
        end else begin
          wr_up.data = c_val;
          if (c_leaf) begin
            wr_own.en   = 1'b1;
            wr_own.addr = c_slot;
            wr_own.data = tok_r2.carry;
            done        = 1'b1;
          end else begin
            tok_out      = tok_r2;
            tok_out.slot = c_slot;
            tok_out.gidx = c_g[CNT_W-1:0];
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/amhpq_ctrl.sv
// ----------------------------------------------------------------------------
// amhpq_ctrl
// command sequencer: entry count, root and last-entry fetch, result register
// ----------------------------------------------------------------------------
module amhpq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  amhpq_pkg::amhpq_cmd_t         cmd,
  output logic                          cmd_stall,
  output logic                          res_valid,
  input  logic                          res_stall,
  output amhpq_pkg::amhpq_res_t         res,
  input  logic                          done,
  input  logic [amhpq_pkg::DATA_W-1:0]  root_data,
  input  logic [amhpq_pkg::DATA_W-1:0]  last_data,
  output logic [amhpq_pkg::CNT_W-1:0]   count,
  output amhpq_pkg::amhpq_tok_t         ins_tok,
  output amhpq_pkg::amhpq_tok_t         pop_tok,
  output amhpq_pkg::amhpq_fetch_t       fetch
);
  import amhpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EMIT  = 4'b0100,
    S_WALK  = 4'b1000
  } state_t;

  state_t            state;
  logic              empty;
  logic [LVL_W-1:0]  fetch_lvl;
  logic [SLOT_W-1:0] fetch_slot;

  logic [CNT_W-1:0]  ins_pos;
  logic [LVL_W-1:0]  cnt_lvl;
  logic [CNT_W-1:0]  last_slot;
  logic              emit_go;
  logic              ins_go;

  assign cmd_stall  = (state != S_IDLE);
  assign ins_pos    = count + CNT_W'(1);
  assign cnt_lvl    = msb_index(count);
  assign last_slot  = count & ~(CNT_W'(1) << cnt_lvl);

  // pop result goes out once the result register is free
  assign emit_go    = (state == S_EMIT) && (!res_valid || !res_stall);
  // insert starts a walk unless the heap is full
  assign ins_go     = (state == S_IDLE) && cmd_valid && (cmd.operation == OP_INSERT) &&
                      (count != CNT_W'(HEAP_DEPTH));

  assign fetch.en   = (state == S_FETCH) || (state == S_EMIT);
  assign fetch.lvl  = fetch_lvl;
  assign fetch.slot = fetch_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      ins_tok   <= '0;
      pop_tok   <= '0;
    end else begin
      ins_tok.valid <= ins_go;
      pop_tok.valid <= emit_go && !empty;
      res_valid     <= emit_go || (res_valid && res_stall);
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.operation == OP_POP) begin
              empty      <= (count == '0);
              fetch_lvl  <= cnt_lvl;
              fetch_slot <= last_slot[SLOT_W-1:0];
              state      <= S_FETCH;
            end else if (count != CNT_W'(HEAP_DEPTH)) begin
              count          <= ins_pos;
              ins_tok.is_pop <= OP_INSERT;
              ins_tok.carry  <= cmd.value;
              ins_tok.slot   <= '0;
              ins_tok.gidx   <= '0;
              ins_tok.path   <= ins_pos;
              ins_tok.rem    <= msb_index(ins_pos);
              state          <= S_WALK;
            end
          end
        end
        S_FETCH: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            res.popped_value   <= empty ? '0 : root_data;
            res.heap_was_empty <= empty;
            if (empty) begin
              state <= S_IDLE;
            end else begin
              count          <= count - CNT_W'(1);
              pop_tok.is_pop <= OP_POP;
              pop_tok.carry  <= last_data;
              pop_tok.slot   <= '0;
              pop_tok.gidx   <= '0;
              pop_tok.path   <= '0;
              pop_tok.rem    <= '0;
              state          <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/abs_min_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// abs_min_heap_priority_queue_top
// binary min-heap of signed words, ordered by magnitude then by signed value
// ----------------------------------------------------------------------------
// The heap is split by level: one cell per level, each with its own level
// memory, and a walker that moves down the row of cells, passing in each
// cell through a registered memory read and then a compare and write. An
// insert bumps the count and walks from the root down the path to the new
// slot, dropping the new value in where it belongs and pushing the larger
// entries one level down. An insert into a full heap is dropped. A pop
// reads the root and the last entry in one fetch, returns the root, and
// walks the last entry down from the root; the walk ends in the cell one
// level below the slot the entry settles in, or in the leaf level it drops
// into. A pop waits for the result register to free, and a pop on an empty
// heap returns zero with the empty flag and starts no walk. One item is in
// work at a time; cmd_stall is high from a walking command until its walk
// ends, and for an empty pop until its result goes out. The result register
// lets a pop result wait on res_stall while further inserts are taken.
// Memory contents need no clearing after reset.
// ----------------------------------------------------------------------------
module abs_min_heap_priority_queue_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  amhpq_pkg::amhpq_cmd_t cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output amhpq_pkg::amhpq_res_t res
);
  import amhpq_pkg::*;

  // walker and memory traffic per level
  amhpq_tok_t        tok_in  [LEVELS];
  amhpq_tok_t        tok_out [LEVELS];
  amhpq_rd_t         rd      [LEVELS];
  amhpq_wr_t         wr_own  [LEVELS];
  amhpq_wr_t         wr_up   [LEVELS];
  logic [DATA_W-1:0] rdata_a [LEVELS];
  logic [DATA_W-1:0] rdata_b [LEVELS];
  logic [LEVELS-1:0] done_vec;

  // sequencer side
  logic [CNT_W-1:0]  count;
  amhpq_tok_t        ins_tok;
  amhpq_tok_t        pop_tok;
  amhpq_fetch_t      fetch;
  logic [DATA_W-1:0] last_data;

  // last entry comes back on port b of the level it lives in
  assign last_data = rdata_b[fetch.lvl];

  amhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .done      (|done_vec),
    .root_data (rdata_a[0]),
    .last_data (last_data),
    .count     (count),
    .ins_tok   (ins_tok),
    .pop_tok   (pop_tok),
    .fetch     (fetch)
  );

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    // level k holds entries 2^k-1 .. 2^(k+1)-2, cut at the heap depth
    localparam int LVL_SIZE = ((2**k) <= (HEAP_DEPTH - (2**k) + 1)) ?
                              (2**k) : (HEAP_DEPTH - (2**k) + 1);
    localparam int LVL_AW   = (LVL_SIZE > 1) ? $clog2(LVL_SIZE) : 1;

    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr_a;
    logic [SLOT_W-1:0] raddr_b;

    // inserts start at the root cell, pops at the cell under the root
    if (k == 0) begin : g_in_root
      assign tok_in[k] = ins_tok;
    end else if (k == 1) begin : g_in_pop
      assign tok_in[k] = pop_tok.valid ? pop_tok : tok_out[k-1];
    end else begin : g_in_chain
      assign tok_in[k] = tok_out[k-1];
    end

    // own writes and hole fills from the cell below share one write port
    if (k < LEVELS - 1) begin : g_wr_mix
      assign we    = wr_own[k].en | wr_up[k+1].en;
      assign waddr = wr_own[k].en ? wr_own[k].addr : wr_up[k+1].addr;
      assign wdata = wr_own[k].en ? wr_own[k].data : wr_up[k+1].data;
    end else begin : g_wr_own
      assign we    = wr_own[k].en;
      assign waddr = wr_own[k].addr;
      assign wdata = wr_own[k].data;
    end

    // fetch of root and last entry takes over the read ports
    if (k == 0) begin : g_rd_root
      assign raddr_a = fetch.en ? '0 : rd[k].addr_a;
    end else begin : g_rd_cell
      assign raddr_a = rd[k].addr_a;
    end
    assign raddr_b = (fetch.en && (fetch.lvl == LVL_W'(k))) ? fetch.slot : rd[k].addr_b;

    amhpq_ram #(
      .DEPTH (LVL_SIZE),
      .AW    (LVL_AW),
      .W     (DATA_W)
    ) u_ram (
      .clk     (clk),
      .we      (we),
      .waddr   (waddr[LVL_AW-1:0]),
      .wdata   (wdata),
      .raddr_a (raddr_a[LVL_AW-1:0]),
      .rdata_a (rdata_a[k]),
      .raddr_b (raddr_b[LVL_AW-1:0]),
      .rdata_b (rdata_b[k])
    );

    amhpq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok_in[k]),
      .count   (count),
      .rdata_a (rdata_a[k]),
      .rdata_b (rdata_b[k]),
      .rd      (rd[k]),
      .wr_own  (wr_own[k]),
      .wr_up   (wr_up[k]),
      .tok_out (tok_out[k]),
      .done    (done_vec[k])
    );
  end

endmodule
